[hw/rtl/dtd_pkg.sv]
// Package for the decimal text to double converter.
// Holds the shared types, state encodings, character codes and float constants.
// Depends on nothing; every other file refers to it by scoped names.
package dtd_pkg;

    // Character codes of the grammar
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Saturation bound of the decimal exponent
    localparam logic [30:0] EXP_MAX = 31'h7FFF_FFFF;

    // Working widths of the float unit
    localparam int P_W = 116;
    localparam int X_W = 14;

    // Double format constants
    localparam logic [10:0] EXP_INF = 11'h7FF;
    localparam logic signed [X_W-1:0] X_MIN   = -14'sd1074;
    localparam logic signed [X_W-1:0] X_BIAS  = 14'sd1075;
    localparam logic signed [X_W-1:0] X_BIG   = 14'sd2047;
    localparam logic signed [X_W-1:0] ADD_FAR = 14'sd110;
    localparam logic signed [X_W-1:0] ADD_TOP = 14'sd5;

    // Significands of 10.0 and of the double nearest 0.1 (times 2^-56)
    localparam logic [52:0] TEN_SIG   = 53'd10;
    localparam logic [52:0] TENTH_SIG = 53'h1999_9999_9999_9A;
    localparam logic signed [X_W-1:0] TENTH_EXP = -14'sd56;

    typedef enum logic [1:0] {
        OP_MUL10,
        OP_MUL01,
        OP_ADD
    } dtd_op_t;

    typedef struct packed {
        logic       start;
        dtd_op_t    op;
        logic [3:0] digit;
    } dtd_req_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_NORM
    } fpu_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL_WAIT,
        C_ADD_GO,
        C_ADD_WAIT,
        C_SCALE,
        C_SCALE_WAIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_INT,
        PH_FRAC,
        PH_ESTART,
        PH_EDIG,
        PH_SKIP
    } phase_t;

endpackage

[hw/rtl/dtd_fpu.sv]
// Shared float unit: multiply by 10.0 or 0.1 and add of a small digit.
// Shift-add multiplier, one-bit normalizer and nearest-even rounding.
// Depends on dtd_pkg.
module dtd_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  dtd_pkg::dtd_req_t req,
    input  logic [62:0]       a,
    output logic              done,
    output logic [62:0]       result
);

    dtd_pkg::fpu_state_t state_reg, state_next;
    logic [dtd_pkg::P_W-1:0] p_reg, p_next;
    logic [dtd_pkg::P_W-1:0] mm_reg, mm_next;
    logic [52:0]             k_reg, k_next;
    logic signed [dtd_pkg::X_W-1:0] x_reg, x_next;
    logic g_reg, g_next;
    logic s_reg, s_next;
    logic done_reg, done_next;
    logic [62:0] res_reg, res_next;

    logic [10:0] e_a;
    logic [10:0] e_eff;
    logic [dtd_pkg::P_W-1:0] m_w;
    logic [dtd_pkg::P_W-1:0] d_w;
    logic signed [dtd_pkg::X_W-1:0] xa;
    logic signed [dtd_pkg::X_W-1:0] sh;
    logic a_zero;
    logic a_inf;

    logic inc;
    logic [53:0] q1;
    logic [52:0] sig;
    logic signed [dtd_pkg::X_W-1:0] x_fin;
    logic signed [dtd_pkg::X_W-1:0] biased;
    logic [62:0] rounded;

    // Unpack the operand
    always_comb
    begin
        e_a    = a[62:52];
        e_eff  = (e_a == 11'd0) ? 11'd1 : e_a;
        m_w    = dtd_pkg::P_W'({(e_a != 11'd0), a[51:0]});
        d_w    = dtd_pkg::P_W'(req.digit);
        xa     = $signed({3'b000, e_eff}) - dtd_pkg::X_BIAS;
        sh     = -xa;
        a_zero = (a == 63'd0);
        a_inf  = (e_a == dtd_pkg::EXP_INF);
    end

    // Round the settled significand to nearest even and pack
    always_comb
    begin
        inc    = g_reg & (s_reg | p_reg[0]);
        q1     = {1'b0, p_reg[52:0]} + 54'(inc);
        sig    = q1[53] ? q1[53:1] : q1[52:0];
        x_fin  = x_reg + (q1[53] ? 14'sd1 : 14'sd0);
        biased = x_fin + dtd_pkg::X_BIAS;
        if (!sig[52])
        begin
            rounded = {11'd0, sig[51:0]};
        end
        else if (biased >= dtd_pkg::X_BIG)
        begin
            rounded = {dtd_pkg::EXP_INF, 52'd0};
        end
        else
        begin
            rounded = {biased[10:0], sig[51:0]};
        end
    end

    // Sequence the operation
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        mm_next    = mm_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        g_next     = g_reg;
        s_next     = s_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            dtd_pkg::F_IDLE:
            begin
                if (req.start)
                begin
                    g_next = 1'b0;
                    s_next = 1'b0;
                    case (req.op)
                        dtd_pkg::OP_ADD:
                        begin
                            if (req.digit == 4'd0 || a_inf || xa >= dtd_pkg::ADD_TOP)
                            begin
                                res_next  = a;
                                done_next = 1'b1;
                            end
                            else if (xa >= 14'sd0)
                            begin
                                p_next     = (m_w << xa[2:0]) + d_w;
                                x_next     = 14'sd0;
                                state_next = dtd_pkg::F_NORM;
                            end
                            else if (sh > dtd_pkg::ADD_FAR)
                            begin
                                p_next     = d_w;
                                x_next     = 14'sd0;
                                state_next = dtd_pkg::F_NORM;
                            end
                            else
                            begin
                                p_next     = m_w + (d_w << sh[6:0]);
                                x_next     = xa;
                                state_next = dtd_pkg::F_NORM;
                            end
                        end
                        default:
                        begin
                            if (a_zero || a_inf)
                            begin
                                res_next  = a;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                p_next  = '0;
                                mm_next = m_w;
                                if (req.op == dtd_pkg::OP_MUL01)
                                begin
                                    k_next = dtd_pkg::TENTH_SIG;
                                    x_next = xa + dtd_pkg::TENTH_EXP;
                                end
                                else
                                begin
                                    k_next = dtd_pkg::TEN_SIG;
                                    x_next = xa;
                                end
                                state_next = dtd_pkg::F_MUL;
                            end
                        end
                    endcase
                end
            end
            dtd_pkg::F_MUL:
            begin
                // Add one shifted partial product per multiplier bit
                if (k_reg[0])
                begin
                    p_next = p_reg + mm_reg;
                end
                mm_next = mm_reg << 1;
                k_next  = k_reg >> 1;
                if (k_reg[52:1] == 52'd0)
                begin
                    state_next = dtd_pkg::F_NORM;
                end
            end
            dtd_pkg::F_NORM:
            begin
                if ((|p_reg[dtd_pkg::P_W-1:53]) || x_reg < dtd_pkg::X_MIN)
                begin
                    // Drop one bit into guard and sticky
                    s_next = s_reg | g_reg;
                    g_next = p_reg[0];
                    p_next = p_reg >> 1;
                    x_next = x_reg + 14'sd1;
                end
                else if (!p_reg[52] && x_reg > dtd_pkg::X_MIN)
                begin
                    p_next = p_reg << 1;
                    x_next = x_reg - 14'sd1;
                end
                else
                begin
                    res_next   = rounded;
                    done_next  = 1'b1;
                    state_next = dtd_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = dtd_pkg::F_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtd_pkg::F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        mm_reg  <= mm_next;
        k_reg   <= k_next;
        x_reg   <= x_next;
        g_reg   <= g_next;
        s_reg   <= s_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[hw/rtl/decimal_text_to_double.sv]
// Decimal text to double converter, top level.
// Parser, exponent tracking and sequencer; uses dtd_fpu and dtd_pkg.
//
// Usage: send one character per word on the input channel (in_valid, in_ready,
// ch), ending the string with a zero byte. The result word (out_valid,
// out_ready, value_bits) carries the IEEE double bits, sign bit left out.
// A non-digit character does not stall the input. A mantissa digit takes a
// multiply by 10 and a digit add on the shared float unit, which uses the
// 4-step shift-add multiplier and the one-bit normalizer. On a zero
// accumulator a zero digit goes through the float unit at once, and a nonzero
// one is walked up by the normalizer one bit per cycle. On the zero byte each
// unit of decimal exponent costs one multiply: by 10 up, by 0.1 down (53
// shift-add steps for 0.1 plus normalization).
// Scaling stops once the value is zero or infinity.
// The result sits in an output register; the block takes the next string
// while it waits, and only holds a finished conversion if that register is
// still full. Reset returns the parser to the integer digits with a zero
// accumulator and clears the output valid flag.
module decimal_text_to_double (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [62:0] value_bits
);

    dtd_pkg::ctrl_state_t state_reg, state_next;
    dtd_pkg::phase_t      phase_reg, phase_next;
    logic [62:0]          accum_reg, accum_next;
    logic [30:0]          dec_reg, dec_next;
    logic [30:0]          expv_reg, expv_next;
    logic                 eneg_reg, eneg_next;
    logic signed [31:0]   escale_reg, escale_next;
    logic [3:0]           digit_reg, digit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [62:0]          value_reg, value_next;

    dtd_pkg::dtd_req_t req;
    logic              fpu_done;
    logic [62:0]       fpu_result;

    logic              accept;
    logic              is_digit;
    logic [3:0]        ch_digit;
    logic [34:0]       expv_ten;
    logic [30:0]       expv_upd;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic              scale_stop;

    dtd_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a      (accum_reg),
        .done   (fpu_done),
        .result (fpu_result)
    );

    // Decode the character and update the explicit exponent
    always_comb
    begin
        accept   = in_valid && (state_reg == dtd_pkg::C_IDLE);
        is_digit = ch inside {[dtd_pkg::CH_ZERO:dtd_pkg::CH_NINE]};
        ch_digit = 4'(ch - dtd_pkg::CH_ZERO);
        expv_ten = ({4'd0, expv_reg} << 3) + ({4'd0, expv_reg} << 1) + 35'(ch_digit);
        expv_upd = (expv_ten > {4'd0, dtd_pkg::EXP_MAX}) ? dtd_pkg::EXP_MAX
                                                         : expv_ten[30:0];
        if (eneg_reg)
        begin
            sum_wide = -($signed({2'b00, expv_reg}) + $signed({2'b00, dec_reg}));
        end
        else
        begin
            sum_wide = $signed({2'b00, expv_reg}) - $signed({2'b00, dec_reg});
        end
        if (sum_wide > $signed({2'b00, dtd_pkg::EXP_MAX}))
        begin
            sum_sat = $signed({1'b0, dtd_pkg::EXP_MAX});
        end
        else if (sum_wide < -$signed({2'b00, dtd_pkg::EXP_MAX}))
        begin
            sum_sat = -$signed({1'b0, dtd_pkg::EXP_MAX});
        end
        else
        begin
            sum_sat = sum_wide[31:0];
        end
        scale_stop = (escale_reg == 32'sd0) || (accum_reg == 63'd0)
                     || (accum_reg[62:52] == dtd_pkg::EXP_INF);
    end

    // Next state and float unit requests
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        dec_next       = dec_reg;
        expv_next      = expv_reg;
        eneg_next      = eneg_reg;
        escale_next    = escale_reg;
        digit_next     = digit_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        req.start      = 1'b0;
        req.op         = dtd_pkg::OP_MUL10;
        req.digit      = digit_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dtd_pkg::C_IDLE:
            begin
                if (accept)
                begin
                    if (ch == dtd_pkg::CH_NUL)
                    begin
                        escale_next = sum_sat;
                        state_next  = dtd_pkg::C_SCALE;
                    end
                    else
                    begin
                        case (phase_reg)
                            dtd_pkg::PH_INT, dtd_pkg::PH_FRAC:
                            begin
                                if (is_digit)
                                begin
                                    req.start  = 1'b1;
                                    digit_next = ch_digit;
                                    state_next = dtd_pkg::C_MUL_WAIT;
                                    if (phase_reg == dtd_pkg::PH_FRAC
                                        && dec_reg != dtd_pkg::EXP_MAX)
                                    begin
                                        dec_next = dec_reg + 31'd1;
                                    end
                                end
                                else if (ch == dtd_pkg::CH_DOT
                                         && phase_reg == dtd_pkg::PH_INT)
                                begin
                                    phase_next = dtd_pkg::PH_FRAC;
                                end
                                else if (ch == dtd_pkg::CH_E_LO || ch == dtd_pkg::CH_E_UP)
                                begin
                                    phase_next = dtd_pkg::PH_ESTART;
                                end
                                else
                                begin
                                    phase_next = dtd_pkg::PH_SKIP;
                                end
                            end
                            dtd_pkg::PH_ESTART:
                            begin
                                if (ch == dtd_pkg::CH_PLUS)
                                begin
                                    phase_next = dtd_pkg::PH_EDIG;
                                end
                                else if (ch == dtd_pkg::CH_MINUS)
                                begin
                                    eneg_next  = 1'b1;
                                    phase_next = dtd_pkg::PH_EDIG;
                                end
                                else if (is_digit)
                                begin
                                    expv_next  = expv_upd;
                                    phase_next = dtd_pkg::PH_EDIG;
                                end
                                else
                                begin
                                    phase_next = dtd_pkg::PH_SKIP;
                                end
                            end
                            dtd_pkg::PH_EDIG:
                            begin
                                if (is_digit)
                                begin
                                    expv_next = expv_upd;
                                end
                                else
                                begin
                                    phase_next = dtd_pkg::PH_SKIP;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            dtd_pkg::C_MUL_WAIT:
            begin
                if (fpu_done)
                begin
                    accum_next = fpu_result;
                    state_next = dtd_pkg::C_ADD_GO;
                end
            end
            dtd_pkg::C_ADD_GO:
            begin
                req.start  = 1'b1;
                req.op     = dtd_pkg::OP_ADD;
                state_next = dtd_pkg::C_ADD_WAIT;
            end
            dtd_pkg::C_ADD_WAIT:
            begin
                if (fpu_done)
                begin
                    accum_next = fpu_result;
                    state_next = dtd_pkg::C_IDLE;
                end
            end
            dtd_pkg::C_SCALE:
            begin
                if (scale_stop)
                begin
                    // Emit once the output register is free, then clear the parse
                    if (!out_valid_reg || out_ready)
                    begin
                        value_next     = accum_reg;
                        out_valid_next = 1'b1;
                        phase_next     = dtd_pkg::PH_INT;
                        accum_next     = 63'd0;
                        dec_next       = 31'd0;
                        expv_next      = 31'd0;
                        eneg_next      = 1'b0;
                        state_next     = dtd_pkg::C_IDLE;
                    end
                end
                else
                begin
                    req.start = 1'b1;
                    if (escale_reg > 32'sd0)
                    begin
                        req.op      = dtd_pkg::OP_MUL10;
                        escale_next = escale_reg - 32'sd1;
                    end
                    else
                    begin
                        req.op      = dtd_pkg::OP_MUL01;
                        escale_next = escale_reg + 32'sd1;
                    end
                    state_next = dtd_pkg::C_SCALE_WAIT;
                end
            end
            dtd_pkg::C_SCALE_WAIT:
            begin
                if (fpu_done)
                begin
                    accum_next = fpu_result;
                    state_next = dtd_pkg::C_SCALE;
                end
            end
            default:
            begin
                state_next = dtd_pkg::C_IDLE;
            end
        endcase
    end

    // Hold control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtd_pkg::C_IDLE;
            phase_reg     <= dtd_pkg::PH_INT;
            accum_reg     <= 63'd0;
            dec_reg       <= 31'd0;
            expv_reg      <= 31'd0;
            eneg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            dec_reg       <= dec_next;
            expv_reg      <= expv_next;
            eneg_reg      <= eneg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        escale_reg <= escale_next;
        digit_reg  <= digit_next;
        value_reg  <= value_next;
    end

    assign in_ready   = (state_reg == dtd_pkg::C_IDLE);
    assign out_valid  = out_valid_reg;
    assign value_bits = value_reg;

endmodule

[hw/rtl/dtd_checker.sv]
// Port-level checker for the decimal text to double converter.
// Watches only the top level's ports; bound to decimal_text_to_double below.
// Depends on dtd_pkg for the character codes and the infinity exponent.
module dtd_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  ch,
    input logic        out_valid,
    input logic        out_ready,
    input logic [62:0] value_bits
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_bits))
        else $error("result word changed while stalled");

    // Never emit a NaN pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value_bits[62:52] != dtd_pkg::EXP_INF) || (value_bits[51:0] == 52'd0))
        else $error("result is a NaN pattern");

    // Drop ready while a terminated string is scaled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ch == dtd_pkg::CH_NUL |=> !in_ready)
        else $error("ready during scaling");

    // Stay ready in the cycle after a non-digit, non-terminator word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ch != dtd_pkg::CH_NUL
        && (ch < dtd_pkg::CH_ZERO || ch > dtd_pkg::CH_NINE) |=> in_ready)
        else $error("non-digit word stalled the input");

endmodule

bind decimal_text_to_double dtd_port_checker u_dtd_checker (.*);

[tb/dtd_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the decimal text to double converter: watches both channels,
// predicts each result with double arithmetic and compares it. Uses dtd_pkg.
module dtd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [62:0] value_bits,
    output int          errors,
    output int          pending,
    output int          results
);
    localparam longint SAT = 64'sd2147483647;

    dtd_pkg::phase_t phase;
    real             mant;
    longint          frac_exp;
    longint          exp_mag;
    bit              exp_neg;
    logic [62:0]     expected_bits[$];

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dtd_pkg::CH_ZERO && c <= dtd_pkg::CH_NINE;
    endfunction

    function automatic bit stuck(input real a);
        logic [63:0] b;
        b = $realtobits(a);
        return a == 0.0 || b[62:52] == 11'h7FF;
    endfunction

    task automatic clear_parse();
        phase    = dtd_pkg::PH_INT;
        mant     = 0.0;
        frac_exp = 0;
        exp_mag  = 0;
        exp_neg  = 1'b0;
    endtask

    // Append one mantissa digit: multiply then add, each rounded on its own
    task automatic push_digit(input logic [7:0] c);
        real scaled;
        scaled = mant * 10.0;
        mant   = scaled + real'(c - dtd_pkg::CH_ZERO);
    endtask

    task automatic push_exp_digit(input logic [7:0] c);
        longint v;
        v       = exp_mag * 10 + longint'(c - dtd_pkg::CH_ZERO);
        exp_mag = (v > SAT) ? SAT : v;
    endtask

    // Apply the decimal exponent by repeated rounded steps and queue the bits
    task automatic finish_number();
        longint      e;
        real         a;
        logic [63:0] b;
        e = frac_exp + (exp_neg ? -exp_mag : exp_mag);
        if (e > SAT) e = SAT;
        if (e < -SAT) e = -SAT;
        a = mant;
        while (e > 0 && !stuck(a)) begin
            a = a * 10.0;
            e--;
        end
        while (e < 0 && !stuck(a)) begin
            a = a * 0.1;
            e++;
        end
        b = $realtobits(a);
        expected_bits.push_back(b[62:0]);
        clear_parse();
    endtask

    task automatic take_char(input logic [7:0] c);
        if (c == dtd_pkg::CH_NUL) begin
            finish_number();
            return;
        end
        case (phase)
            dtd_pkg::PH_INT:
                if (is_digit(c)) push_digit(c);
                else if (c == dtd_pkg::CH_DOT) phase = dtd_pkg::PH_FRAC;
                else if (c == dtd_pkg::CH_E_LO || c == dtd_pkg::CH_E_UP)
                    phase = dtd_pkg::PH_ESTART;
                else phase = dtd_pkg::PH_SKIP;
            dtd_pkg::PH_FRAC:
                if (is_digit(c)) begin
                    push_digit(c);
                    if (frac_exp > -SAT) frac_exp--;
                end
                else if (c == dtd_pkg::CH_E_LO || c == dtd_pkg::CH_E_UP)
                    phase = dtd_pkg::PH_ESTART;
                else phase = dtd_pkg::PH_SKIP;
            dtd_pkg::PH_ESTART:
                if (c == dtd_pkg::CH_PLUS) phase = dtd_pkg::PH_EDIG;
                else if (c == dtd_pkg::CH_MINUS) begin
                    exp_neg = 1'b1;
                    phase   = dtd_pkg::PH_EDIG;
                end
                else if (is_digit(c)) begin
                    push_exp_digit(c);
                    phase = dtd_pkg::PH_EDIG;
                end
                else phase = dtd_pkg::PH_SKIP;
            dtd_pkg::PH_EDIG:
                if (is_digit(c)) push_exp_digit(c);
                else phase = dtd_pkg::PH_SKIP;
            default: ;
        endcase
    endtask

    initial
    begin
        errors  = 0;
        results = 0;
        clear_parse();
    end

    assign pending = expected_bits.size();

    // Predict on each accepted character, compare each accepted result word
    always @(posedge clk)
    begin
        logic [62:0] want;
        if (rst_n) begin
            if (in_valid && in_ready) take_char(ch);
            if (out_valid && out_ready) begin
                results++;
                if (expected_bits.size() == 0) begin
                    $error("value_bits: no result expected, actual %h", value_bits);
                    errors++;
                end
                else begin
                    want = expected_bits.pop_front();
                    if (want !== value_bits) begin
                        $error("value_bits: expected %h, actual %h", want, value_bits);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_decimal_text_to_double.sv]
`timescale 1ns / 100ps
// Testbench top for decimal_text_to_double: drives character strings and
// receiver stalls, and gives the verdict. Uses dtd_checker and dtd_pkg.
module tb_decimal_text_to_double;
    localparam int CYCLE_LIMIT = 10000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic [62:0] value_bits;
    int          errors;
    int          pending;
    int          results;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          holdoff_cycles;
    int          cycles;
    int          strings_sent;
    int          chars_sent;
    logic [7:0]  text[$];

    decimal_text_to_double dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
        .out_valid(out_valid), .out_ready(out_ready), .value_bits(value_bits)
    );

    dtd_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
        .out_valid(out_valid), .out_ready(out_ready), .value_bits(value_bits),
        .errors(errors), .pending(pending), .results(results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            out_ready      <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle cycle by cycle, then send one word and hold it until accepted
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) send_char(text[i]);
        send_char(dtd_pkg::CH_NUL);
        strings_sent++;
        text.delete();
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_text();
    endtask

    task automatic add_digits(input int n);
        repeat (n) text.push_back(8'(dtd_pkg::CH_ZERO + $urandom_range(9)));
    endtask

    task automatic add_noise();
        text.push_back(8'($urandom_range(1, 255)));
    endtask

    // Mostly well-formed numbers with random content; some broken or noisy
    task automatic random_number();
        int kind;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 6)) add_noise();
        end
        else
        begin
            add_digits($urandom_range(0, 18));
            if ($urandom_range(1))
            begin
                text.push_back(dtd_pkg::CH_DOT);
                add_digits($urandom_range(0, 8));
            end
            if ($urandom_range(2) != 0)
            begin
                text.push_back($urandom_range(1) ? dtd_pkg::CH_E_LO : dtd_pkg::CH_E_UP);
                case ($urandom_range(2))
                    0: text.push_back(dtd_pkg::CH_PLUS);
                    1: text.push_back(dtd_pkg::CH_MINUS);
                    default: ;
                endcase
                add_digits($urandom_range(0, 2));
            end
            if (kind < 25)
            begin
                text.insert($urandom_range(text.size()), 8'($urandom_range(1, 255)));
                if ($urandom_range(1)) add_noise();
            end
        end
        send_text();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        ch             = 8'h00;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        cycles         = 0;
        strings_sent   = 0;
        chars_sent     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: grammar corners, saturation, overflow to inf and to zero
        send_literal("");
        send_literal("0");
        send_literal("123.456");
        send_literal("1.5E+3");
        send_literal("2e");
        send_literal("7e-");
        send_literal("-5");
        send_literal(" 7");
        send_literal("1.2.3");
        send_literal("1e5.3");
        send_literal("1e+-3");
        send_literal("1e400");
        send_literal("1e-400");
        send_literal("3e99999999999");
        send_literal("4e-99999999999");
        send_literal(".5x9");
        send_literal("0e-99999999999");

        // Random phases under different idle patterns
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 35 : 61) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 35 : 61) : 0;
            if (ph == 2) holdoff_cycles <= 20000;
            repeat (20) random_number();
        end

        // Mantissa overflow: enough nines to reach infinity
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (320) text.push_back(dtd_pkg::CH_NINE);
        send_text();
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d strings (%0d characters), checked %0d results.",
                 strings_sent, chars_sent, results);
        if (errors == 0 && pending == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_fpu.sv
hw/rtl/decimal_text_to_double.sv
hw/rtl/dtd_checker.sv
tb/dtd_checker.sv
tb/tb_decimal_text_to_double.sv
